// ===== hw/rtl/sci_pkg.sv =====
// Shared widths, latencies and the per-item context record for the
// segment/circle intersection pipeline. No dependencies.
`default_nettype none

package sci_pkg;

	// Coordinate word and the widths that follow from it.
	localparam int CW      = 32;
	localparam int DW      = CW + 1;        // endpoint and center differences
	localparam int PW      = 2 * DW;        // products of two differences
	localparam int AW      = PW + 2;        // a, b and c of the quadratic
	localparam int MW      = AW + 2;        // operand width of the wide multiplier
	localparam int MH      = MW / 2;        // half operand, one partial product
	localparam int PRW     = 2 * MW;        // wide product and discriminant
	localparam int RW      = PRW / 2;       // square root bits, one per stage
	localparam int RMW     = RW + 3;        // square root remainder
	localparam int QB      = CW + 3;        // quotient magnitude bits kept
	localparam int QW      = QB + 2;        // signed rounded quotient
	localparam int EW      = QW + 1;        // offsets from an endpoint
	localparam int SQW     = 2 * EW;        // squared offsets

	localparam int MUL_LAT = 4;
	localparam int DIV_LAT = QB + 4;
	localparam int LAT     = 3 + MUL_LAT + 1 + RW + 1 + MUL_LAT + DIV_LAT + 3 + 1;

	typedef struct packed {
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] y1;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic [AW-1:0]        a;
		logic signed [AW-1:0] b;
		logic                 plus_first;
		logic                 degen;
		logic                 neg;
		logic                 tan;
	} ctx_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sci_mul.sv =====
// Pipelined signed multiplier, sci_pkg::MW by sci_pkg::MW bits, built from
// four half-width partial products. Depends on sci_pkg.
`default_nettype none

module sci_mul (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [sci_pkg::MW-1:0]    op_a,
	input  logic signed [sci_pkg::MW-1:0]    op_b,
	output logic signed [sci_pkg::PRW-1:0]   prod
);

	localparam int MW  = sci_pkg::MW;
	localparam int MH  = sci_pkg::MH;
	localparam int PRW = sci_pkg::PRW;

	logic [MW-1:0]     am_s1, bm_s1;
	logic              sg_s1, sg_s2, sg_s3;
	logic [2*MH-1:0]   p00_s2, p01_s2, p10_s2, p11_s2;
	logic [PRW-1:0]    mag_s3;
	logic signed [PRW-1:0] prod_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			am_s1   <= op_a[MW-1] ? (~op_a + 1'b1) : op_a;
			bm_s1   <= op_b[MW-1] ? (~op_b + 1'b1) : op_b;
			sg_s1   <= op_a[MW-1] ^ op_b[MW-1];

			p00_s2  <= am_s1[MH-1:0]  * bm_s1[MH-1:0];
			p01_s2  <= am_s1[MH-1:0]  * bm_s1[MW-1:MH];
			p10_s2  <= am_s1[MW-1:MH] * bm_s1[MH-1:0];
			p11_s2  <= am_s1[MW-1:MH] * bm_s1[MW-1:MH];
			sg_s2   <= sg_s1;

			mag_s3  <= PRW'(p00_s2) + ((PRW'(p01_s2) + PRW'(p10_s2)) << MH)
				+ (PRW'(p11_s2) << MW);
			sg_s3   <= sg_s2;

			prod_s4 <= sg_s3 ? (~mag_s3 + 1'b1) : mag_s3;
		end
	end

	assign prod = prod_s4;

endmodule

`default_nettype wire

// ===== hw/rtl/sci_div.sv =====
// Pipelined restoring divider with round-half-away-from-zero, one quotient
// bit per stage. Flags quotients too large to matter. Depends on sci_pkg.
`default_nettype none

module sci_div (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [sci_pkg::PRW-1:0]  num,
	input  logic [sci_pkg::AW-1:0]          den,
	output logic signed [sci_pkg::QW-1:0]   quo,
	output logic                            big
);

	localparam int PRW = sci_pkg::PRW;
	localparam int AW  = sci_pkg::AW;
	localparam int QB  = sci_pkg::QB;
	localparam int QW  = sci_pkg::QW;

	logic [PRW-1:0] mag_s1;
	logic           neg_s1;
	logic [AW-1:0]  den_s1;

	logic [AW-1:0]  rem_s2, den_s2;
	logic [QB-1:0]  low_s2;
	logic           neg_s2, big_s2;

	logic [AW-1:0]  rem_st [QB];
	logic [AW-1:0]  den_st [QB];
	logic [QB-1:0]  qb_st  [QB];
	logic [QB-1:0]  low_st [QB];
	logic           neg_st [QB];
	logic           big_st [QB];

	logic [QB:0]    qr_sr;
	logic           neg_sr, big_sr;
	logic signed [QW-1:0] quo_sq;
	logic           big_sq;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= num[PRW-1] ? (~num + 1'b1) : num;
			neg_s1 <= num[PRW-1];
			den_s1 <= den;

			// Anything at or above den * 2^QB cannot be a point on the segment.
			big_s2 <= mag_s1 >= PRW'({den_s1, {QB{1'b0}}});
			rem_s2 <= mag_s1[AW+QB-1:QB];
			low_s2 <= mag_s1[QB-1:0];
			den_s2 <= den_s1;
			neg_s2 <= neg_s1;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_it
		logic [AW-1:0] rem_in, den_in;
		logic [QB-1:0] qb_in, low_in;
		logic          neg_in, big_in, ge;
		logic [AW:0]   tr, diff;

		if (k == 0) begin : g_first
			assign rem_in = rem_s2;
			assign den_in = den_s2;
			assign qb_in  = '0;
			assign low_in = low_s2;
			assign neg_in = neg_s2;
			assign big_in = big_s2;
		end else begin : g_next
			assign rem_in = rem_st[k-1];
			assign den_in = den_st[k-1];
			assign qb_in  = qb_st[k-1];
			assign low_in = low_st[k-1];
			assign neg_in = neg_st[k-1];
			assign big_in = big_st[k-1];
		end

		assign tr   = {rem_in, low_in[QB-1]};
		assign ge   = tr >= {1'b0, den_in};
		assign diff = tr - {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_st[k] <= ge ? diff[AW-1:0] : tr[AW-1:0];
				qb_st[k]  <= {qb_in[QB-2:0], ge};
				low_st[k] <= {low_in[QB-2:0], 1'b0};
				den_st[k] <= den_in;
				neg_st[k] <= neg_in;
				big_st[k] <= big_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qr_sr  <= {1'b0, qb_st[QB-1]}
				+ (QB+1)'({rem_st[QB-1], 1'b0} >= {1'b0, den_st[QB-1]});
			neg_sr <= neg_st[QB-1];
			big_sr <= big_st[QB-1];

			quo_sq <= neg_sr ? -$signed({1'b0, qr_sr}) : $signed({1'b0, qr_sr});
			big_sq <= big_sr;
		end
	end

	assign quo = quo_sq;
	assign big = big_sq;

endmodule

`default_nettype wire

// ===== hw/rtl/segment_circle_intersection_unit.sv =====
// Segment/circle intersection unit, top level. Depends on sci_pkg, sci_mul
// and sci_div.
//
// A request beat carries a segment's endpoints and a circle's center and
// radius, all signed Q16.16 (radius unsigned Q15.16). A response beat carries the
// number of intersection points strictly inside the segment (0 to 2) and
// those points in order, unused points zero. Both channels move a beat at a
// rising edge where valid is high and stall is low.
//
// The unit is a fixed pipeline of sci_pkg::LAT stages: one request beat is
// taken every cycle in which req_stall is low.
// The depth is set by the discriminant square root (one root bit per stage)
// and the four dividers (one quotient bit per stage).
//
// While a response is held by rsp_stall, the whole pipeline freezes and
// req_stall is raised; nothing is lost or repeated. Reset clears the valid
// bit of every stage, so the pipeline starts empty.
`default_nettype none

module segment_circle_intersection_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic signed [sci_pkg::CW-1:0] seg_x1,
	input  logic signed [sci_pkg::CW-1:0] seg_y1,
	input  logic signed [sci_pkg::CW-1:0] seg_x2,
	input  logic signed [sci_pkg::CW-1:0] seg_y2,
	input  logic signed [sci_pkg::CW-1:0] center_x,
	input  logic signed [sci_pkg::CW-1:0] center_y,
	input  logic [sci_pkg::CW-2:0]        radius,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [1:0]                    hit_count,
	output logic signed [sci_pkg::CW-1:0] point1_x,
	output logic signed [sci_pkg::CW-1:0] point1_y,
	output logic signed [sci_pkg::CW-1:0] point2_x,
	output logic signed [sci_pkg::CW-1:0] point2_y
);

	localparam int CW      = sci_pkg::CW;
	localparam int DW      = sci_pkg::DW;
	localparam int PW      = sci_pkg::PW;
	localparam int AW      = sci_pkg::AW;
	localparam int MW      = sci_pkg::MW;
	localparam int PRW     = sci_pkg::PRW;
	localparam int RW      = sci_pkg::RW;
	localparam int RMW     = sci_pkg::RMW;
	localparam int QW      = sci_pkg::QW;
	localparam int EW      = sci_pkg::EW;
	localparam int SQW     = sci_pkg::SQW;
	localparam int MUL_LAT = sci_pkg::MUL_LAT;
	localparam int DIV_LAT = sci_pkg::DIV_LAT;
	localparam int LAT     = sci_pkg::LAT;

	function automatic logic [CW-1:0] clamp_cw(input logic signed [EW-1:0] v);
		logic fits;
		fits = (v[EW-1:CW-1] == '0) || (v[EW-1:CW-1] == '1);
		if (fits) begin
			return v[CW-1:0];
		end else if (v[EW-1]) begin
			return {1'b1, {(CW-1){1'b0}}};
		end else begin
			return {1'b0, {(CW-1){1'b1}}};
		end
	endfunction

	logic              adv;
	logic [LAT-1:0]    vld_q;

	// Stage 1: differences.
	logic signed [CW-1:0] x1_s1, y1_s1;
	logic signed [DW-1:0] dx_s1, dy_s1, fx_s1, fy_s1;
	logic [CW-2:0]        r_s1;

	// Stage 2: products of differences.
	logic signed [CW-1:0] x1_s2, y1_s2;
	logic signed [DW-1:0] dx_s2, dy_s2;
	logic signed [PW-1:0] dxx_s2, dyy_s2, fxdx_s2, fydy_s2, fxx_s2, fyy_s2;
	logic [PW-1:0]        rr_s2;

	// Stage 3: quadratic coefficients.
	logic [AW-1:0]        a_s3;
	logic signed [AW-1:0] b_s3, c_s3;
	sci_pkg::ctx_t        ctx_s3;

	logic signed [PRW-1:0] bb, ac, disc_d;
	sci_pkg::ctx_t         ctx_m_dl [MUL_LAT];
	sci_pkg::ctx_t         ctx_d4;

	// Stage 4: discriminant.
	logic signed [PRW-1:0] disc_s4;
	sci_pkg::ctx_t         ctx_s4;

	// Square root stages.
	logic [RMW-1:0]   sq_rem_st  [RW];
	logic [RW-1:0]    sq_root_st [RW];
	logic [PRW-1:0]   sq_dsh_st  [RW];
	sci_pkg::ctx_t    sq_ctx_st  [RW];

	// Stage 5: line parameters of the two roots, ordered.
	logic signed [MW-1:0] b_ext, s_ext, tp, tm;
	logic signed [MW-1:0] t1_s5, t2_s5, dxe_s5, dye_s5;
	sci_pkg::ctx_t        ctx_s5;

	logic signed [PRW-1:0] nx [2];
	logic signed [PRW-1:0] ny [2];
	sci_pkg::ctx_t         ctx_p_dl [MUL_LAT];

	logic signed [QW-1:0]  qx [2];
	logic signed [QW-1:0]  qy [2];
	logic                  bx [2];
	logic                  by [2];
	sci_pkg::ctx_t         ctx_q_dl [DIV_LAT];

	// Stages 6 to 8: keep test.
	logic signed [EW-1:0]  qx_s6 [2];
	logic signed [EW-1:0]  qy_s6 [2];
	logic signed [EW-1:0]  ex_s6 [2];
	logic signed [EW-1:0]  ey_s6 [2];
	logic                  big_s6 [2];
	sci_pkg::ctx_t         ctx_s6;

	logic signed [EW-1:0]  qx_s7 [2];
	logic signed [EW-1:0]  qy_s7 [2];
	logic signed [SQW-1:0] qxx_s7 [2];
	logic signed [SQW-1:0] qyy_s7 [2];
	logic signed [SQW-1:0] exx_s7 [2];
	logic signed [SQW-1:0] eyy_s7 [2];
	logic                  big_s7 [2];
	sci_pkg::ctx_t         ctx_s7;

	logic [SQW:0]          d1 [2];
	logic [SQW:0]          d2 [2];
	logic signed [EW-1:0]  px_s8 [2];
	logic signed [EW-1:0]  py_s8 [2];
	logic                  kept_s8 [2];
	sci_pkg::ctx_t         ctx_s8;

	// Output stage.
	logic              k1, k2;
	logic [1:0]        cnt_d;
	logic [CW-1:0]     p1x_d, p1y_d, p2x_d, p2y_d;
	logic [1:0]        cnt_s9;
	logic [CW-1:0]     p1x_s9, p1y_s9, p2x_s9, p2y_s9;

	assign rsp_valid = vld_q[LAT-1];
	assign adv       = !(rsp_valid && rsp_stall);
	assign req_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], req_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s1   <= seg_x1;
			y1_s1   <= seg_y1;
			dx_s1   <= DW'(seg_x2) - DW'(seg_x1);
			dy_s1   <= DW'(seg_y2) - DW'(seg_y1);
			fx_s1   <= DW'(seg_x1) - DW'(center_x);
			fy_s1   <= DW'(seg_y1) - DW'(center_y);
			r_s1    <= radius;

			x1_s2   <= x1_s1;
			y1_s2   <= y1_s1;
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			dxx_s2  <= dx_s1 * dx_s1;
			dyy_s2  <= dy_s1 * dy_s1;
			fxdx_s2 <= fx_s1 * dx_s1;
			fydy_s2 <= fy_s1 * dy_s1;
			fxx_s2  <= fx_s1 * fx_s1;
			fyy_s2  <= fy_s1 * fy_s1;
			rr_s2   <= r_s1 * r_s1;

			a_s3    <= AW'(dxx_s2) + AW'(dyy_s2);
			b_s3    <= AW'(fxdx_s2) + AW'(fydy_s2);
			c_s3    <= AW'(fxx_s2) + AW'(fyy_s2) - AW'(rr_s2);
			ctx_s3.x1         <= x1_s2;
			ctx_s3.y1         <= y1_s2;
			ctx_s3.dx         <= dx_s2;
			ctx_s3.dy         <= dy_s2;
			ctx_s3.a          <= AW'(dxx_s2) + AW'(dyy_s2);
			ctx_s3.b          <= AW'(fxdx_s2) + AW'(fydy_s2);
			ctx_s3.plus_first <= (dx_s2 > 0) || (dx_s2 == 0 && dy_s2 > 0);
			ctx_s3.degen      <= (dx_s2 == 0) && (dy_s2 == 0);
			ctx_s3.neg        <= 1'b0;
			ctx_s3.tan        <= 1'b0;
		end
	end

	sci_mul u_mul_bb (
		.clk  (clk),
		.en   (adv),
		.op_a ({{(MW-AW){b_s3[AW-1]}}, b_s3}),
		.op_b ({{(MW-AW){b_s3[AW-1]}}, b_s3}),
		.prod (bb)
	);

	sci_mul u_mul_ac (
		.clk  (clk),
		.en   (adv),
		.op_a ({{(MW-AW){1'b0}}, a_s3}),
		.op_b ({{(MW-AW){c_s3[AW-1]}}, c_s3}),
		.prod (ac)
	);

	assign disc_d = bb - ac;

	always_comb begin
		ctx_d4     = ctx_m_dl[MUL_LAT-1];
		ctx_d4.neg = disc_d[PRW-1];
		ctx_d4.tan = disc_d == '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_m_dl[0] <= ctx_s3;
			for (int i = 1; i < MUL_LAT; i++) begin
				ctx_m_dl[i] <= ctx_m_dl[i-1];
			end

			disc_s4 <= disc_d;
			ctx_s4  <= ctx_d4;
		end
	end

	// Integer square root of the discriminant, two radicand bits per stage.
	// A negative discriminant runs through too; its result is never used.
	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		logic [RMW-1:0] rem_in, tr, trial;
		logic [RW-1:0]  root_in;
		logic [PRW-1:0] dsh_in;
		sci_pkg::ctx_t  ctx_in;
		logic           ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign dsh_in  = disc_s4;
			assign ctx_in  = ctx_s4;
		end else begin : g_next
			assign rem_in  = sq_rem_st[k-1];
			assign root_in = sq_root_st[k-1];
			assign dsh_in  = sq_dsh_st[k-1];
			assign ctx_in  = sq_ctx_st[k-1];
		end

		assign tr    = {rem_in[RMW-3:0], dsh_in[PRW-1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};
		assign ge    = tr >= trial;

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rem_st[k]  <= ge ? (tr - trial) : tr;
				sq_root_st[k] <= {root_in[RW-2:0], ge};
				sq_dsh_st[k]  <= {dsh_in[PRW-3:0], 2'b00};
				sq_ctx_st[k]  <= ctx_in;
			end
		end
	end

	assign b_ext = {{(MW-AW){sq_ctx_st[RW-1].b[AW-1]}}, sq_ctx_st[RW-1].b};
	assign s_ext = {1'b0, sq_root_st[RW-1][MW-2:0]};
	assign tp    = s_ext - b_ext;
	assign tm    = -b_ext - s_ext;

	always_ff @(posedge clk) begin
		if (adv) begin
			t1_s5  <= sq_ctx_st[RW-1].plus_first ? tp : tm;
			t2_s5  <= sq_ctx_st[RW-1].plus_first ? tm : tp;
			dxe_s5 <= {{(MW-DW){sq_ctx_st[RW-1].dx[DW-1]}}, sq_ctx_st[RW-1].dx};
			dye_s5 <= {{(MW-DW){sq_ctx_st[RW-1].dy[DW-1]}}, sq_ctx_st[RW-1].dy};
			ctx_s5 <= sq_ctx_st[RW-1];

			ctx_p_dl[0] <= ctx_s5;
			for (int i = 1; i < MUL_LAT; i++) begin
				ctx_p_dl[i] <= ctx_p_dl[i-1];
			end

			ctx_q_dl[0] <= ctx_p_dl[MUL_LAT-1];
			for (int i = 1; i < DIV_LAT; i++) begin
				ctx_q_dl[i] <= ctx_q_dl[i-1];
			end
		end
	end

	// Root 0 is reported first when kept, root 1 second.
	for (genvar r = 0; r < 2; r++) begin : g_root
		sci_mul u_mul_x (
			.clk  (clk),
			.en   (adv),
			.op_a (dxe_s5),
			.op_b (r == 0 ? t1_s5 : t2_s5),
			.prod (nx[r])
		);

		sci_mul u_mul_y (
			.clk  (clk),
			.en   (adv),
			.op_a (dye_s5),
			.op_b (r == 0 ? t1_s5 : t2_s5),
			.prod (ny[r])
		);

		sci_div u_div_x (
			.clk  (clk),
			.en   (adv),
			.num  (nx[r]),
			.den  (ctx_p_dl[MUL_LAT-1].a),
			.quo  (qx[r]),
			.big  (bx[r])
		);

		sci_div u_div_y (
			.clk  (clk),
			.en   (adv),
			.num  (ny[r]),
			.den  (ctx_p_dl[MUL_LAT-1].a),
			.quo  (qy[r]),
			.big  (by[r])
		);
	end

	for (genvar r = 0; r < 2; r++) begin : g_keep
		assign d1[r] = (SQW+1)'(qxx_s7[r]) + (SQW+1)'(qyy_s7[r]);
		assign d2[r] = (SQW+1)'(exx_s7[r]) + (SQW+1)'(eyy_s7[r]);

		always_ff @(posedge clk) begin
			if (adv) begin
				qx_s6[r]  <= {qx[r][QW-1], qx[r]};
				qy_s6[r]  <= {qy[r][QW-1], qy[r]};
				ex_s6[r]  <= {qx[r][QW-1], qx[r]}
					- {{(EW-DW){ctx_q_dl[DIV_LAT-1].dx[DW-1]}}, ctx_q_dl[DIV_LAT-1].dx};
				ey_s6[r]  <= {qy[r][QW-1], qy[r]}
					- {{(EW-DW){ctx_q_dl[DIV_LAT-1].dy[DW-1]}}, ctx_q_dl[DIV_LAT-1].dy};
				big_s6[r] <= bx[r] || by[r];

				qx_s7[r]  <= qx_s6[r];
				qy_s7[r]  <= qy_s6[r];
				qxx_s7[r] <= qx_s6[r] * qx_s6[r];
				qyy_s7[r] <= qy_s6[r] * qy_s6[r];
				exx_s7[r] <= ex_s6[r] * ex_s6[r];
				eyy_s7[r] <= ey_s6[r] * ey_s6[r];
				big_s7[r] <= big_s6[r];

				// Both squared endpoint distances must stay below the
				// squared segment length.
				kept_s8[r] <= !big_s7[r]
					&& d1[r] < (SQW+1)'(ctx_s7.a) && d2[r] < (SQW+1)'(ctx_s7.a);
				px_s8[r]   <= {{(EW-CW){ctx_s7.x1[CW-1]}}, ctx_s7.x1} + qx_s7[r];
				py_s8[r]   <= {{(EW-CW){ctx_s7.y1[CW-1]}}, ctx_s7.y1} + qy_s7[r];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s6 <= ctx_q_dl[DIV_LAT-1];
			ctx_s7 <= ctx_s6;
			ctx_s8 <= ctx_s7;
		end
	end

	// A tangent point is counted once, through the first root only.
	assign k1 = kept_s8[0] && !ctx_s8.neg && !ctx_s8.degen;
	assign k2 = kept_s8[1] && !ctx_s8.neg && !ctx_s8.degen && !ctx_s8.tan;

	always_comb begin
		cnt_d = 2'd0;
		p1x_d = '0;
		p1y_d = '0;
		p2x_d = '0;
		p2y_d = '0;
		if (k1) begin
			cnt_d = 2'd1;
			p1x_d = clamp_cw(px_s8[0]);
			p1y_d = clamp_cw(py_s8[0]);
			if (k2) begin
				cnt_d = 2'd2;
				p2x_d = clamp_cw(px_s8[1]);
				p2y_d = clamp_cw(py_s8[1]);
			end
		end else if (k2) begin
			cnt_d = 2'd1;
			p1x_d = clamp_cw(px_s8[1]);
			p1y_d = clamp_cw(py_s8[1]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cnt_s9 <= cnt_d;
			p1x_s9 <= p1x_d;
			p1y_s9 <= p1y_d;
			p2x_s9 <= p2x_d;
			p2y_s9 <= p2y_d;
		end
	end

	assign hit_count = cnt_s9;
	assign point1_x  = p1x_s9;
	assign point1_y  = p1y_s9;
	assign point2_x  = p2x_s9;
	assign point2_y  = p2y_s9;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> hit_count != 2'd3)
		else $error("hit_count out of range");

	a_no_hit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && hit_count == 2'd0 |-> point1_x == '0 && point1_y == '0)
		else $error("first point not zero with no hits");

	a_one_hit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && hit_count != 2'd2 |-> point2_x == '0 && point2_y == '0)
		else $error("second point not zero with fewer than two hits");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without a held response");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> vld_q[0])
		else $error("accepted beat did not enter the pipeline");

endmodule

`default_nettype wire
